/* hdl/lavm_pkg.sv */
// shared types and constants for the look-at view matrix unit
package lavm_pkg;

  localparam int unsigned VEC_BITS = 72;
  localparam int unsigned NRM_BITS = 30;
  localparam int unsigned SUM_BITS = 62;
  localparam int unsigned ROOT_BITS = 31;

  typedef struct packed {
    logic [NRM_BITS-1:0] a0;
    logic [NRM_BITS-1:0] a1;
    logic [NRM_BITS-1:0] a2;
    logic [2:0]          neg;
    logic                zero;
  } nrm_t;

endpackage

/* hdl/look_at_view_matrix_unit.sv */
// top level of the look-at view matrix unit
//
// command port: raise start with eye, target and up vectors (signed
// fixed point); the word is taken at an edge where start is high and
// busy is low.  busy stays high after each accept while the spacing
// counter runs down, so no new item is taken before then; one item per four result rows.
// results: four rows leave on consecutive cycles, each marked by
// valid_o for one cycle, row_index_o counting 0..3 and last_row_o on
// the final row.  degenerate_o is the same on all four rows.
// row 0 reaches the ports through the input register, then the three
// normalizers in series (scaling front end, square root of one bit per
// stage, divide of one quotient bit per stage) with the product and
// difference registers of a cross product before the second and third,
// and the dot product, sum and row load registers at the end.
// items overlap freely in the pipeline; the receiver cannot stall.
// reset clears all valid bits, the accept spacing counter and the row
// sequencer; items in flight are dropped.
module look_at_view_matrix_unit #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [31:0]          eye_x_i,
  input  logic signed [31:0]          eye_y_i,
  input  logic signed [31:0]          eye_z_i,
  input  logic signed [31:0]          target_x_i,
  input  logic signed [31:0]          target_y_i,
  input  logic signed [31:0]          target_z_i,
  input  logic signed [31:0]          upvec_x_i,
  input  logic signed [31:0]          upvec_y_i,
  input  logic signed [31:0]          upvec_z_i,
  output logic                        valid_o,
  output logic [1:0]                  row_index_o,
  output logic signed [31:0]          elem0_o,
  output logic signed [31:0]          elem1_o,
  output logic signed [31:0]          elem2_o,
  output logic signed [31:0]          elem3_o,
  output logic                        last_row_o,
  output logic                        degenerate_o
);
  localparam int unsigned VB = lavm_pkg::VEC_BITS;
  localparam int unsigned WB = WORD_BITS;

  logic [1:0] gap_q;
  logic acc;
  assign busy = (gap_q != 2'd0);
  assign acc = start && !busy;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) gap_q <= '0;
    else if (acc) gap_q <= 2'd3;
    else if (gap_q != 2'd0) gap_q <= gap_q - 2'd1;
  end

  // input register
  logic v0_q;
  logic signed [31:0] e_q [3];
  logic signed [31:0] u_q [3];
  logic signed [VB-1:0] d_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else v0_q <= acc;
  end
  always_ff @(posedge clk_i) begin
    e_q[0] <= eye_x_i; e_q[1] <= eye_y_i; e_q[2] <= eye_z_i;
    u_q[0] <= upvec_x_i; u_q[1] <= upvec_y_i; u_q[2] <= upvec_z_i;
    d_q[0] <= VB'(eye_x_i) - VB'(target_x_i);
    d_q[1] <= VB'(eye_y_i) - VB'(target_y_i);
    d_q[2] <= VB'(eye_z_i) - VB'(target_z_i);
  end

  // eye travels along the whole pipeline and up along the first normalizer in shift lines
  localparam int unsigned NL = 4 + lavm_pkg::ROOT_BITS + FRAC_BITS + 2 + 1;
  localparam int unsigned PL = 3 * NL + 4;
  logic signed [31:0] ed_q [PL+1][3];
  logic signed [31:0] ud_q [NL+1][3];
  always_comb begin
    ed_q[0] = e_q; ud_q[0] = u_q;
  end
  for (genvar g = 0; g < PL; g++) begin : g_eline
    always_ff @(posedge clk_i) ed_q[g+1] <= ed_q[g];
  end
  for (genvar g = 0; g < NL; g++) begin : g_uline
    always_ff @(posedge clk_i) ud_q[g+1] <= ud_q[g];
  end

  // forward axis
  logic fv;
  logic signed [WB-1:0] f0, f1, f2;
  logic fdeg;
  lavm_unit_vec #(.WORD_BITS(WB), .FRAC_BITS(FRAC_BITS)) u_f (
    .clk_i, .rst_ni, .valid_i(v0_q), .v0_i(d_q[0]), .v1_i(d_q[1]), .v2_i(d_q[2]),
    .valid_o(fv), .n0_o(f0), .n1_o(f1), .n2_o(f2), .deg_o(fdeg));

  // cross(up, f): products then difference
  logic signed [VB-1:0] p1_q [6];
  logic signed [VB-1:0] c1_q [3];
  logic signed [WB-1:0] fd_q [2][3];
  logic cv_q [2];
  logic cdeg_q [2];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin cv_q[0] <= 1'b0; cv_q[1] <= 1'b0; end
    else begin cv_q[0] <= fv; cv_q[1] <= cv_q[0]; end
  end
  always_ff @(posedge clk_i) begin
    p1_q[0] <= VB'(ud_q[NL][1]) * VB'(f2);
    p1_q[1] <= VB'(ud_q[NL][2]) * VB'(f1);
    p1_q[2] <= VB'(ud_q[NL][2]) * VB'(f0);
    p1_q[3] <= VB'(ud_q[NL][0]) * VB'(f2);
    p1_q[4] <= VB'(ud_q[NL][0]) * VB'(f1);
    p1_q[5] <= VB'(ud_q[NL][1]) * VB'(f0);
    c1_q[0] <= p1_q[0] - p1_q[1];
    c1_q[1] <= p1_q[2] - p1_q[3];
    c1_q[2] <= p1_q[4] - p1_q[5];
    fd_q[0] <= '{f0, f1, f2}; fd_q[1] <= fd_q[0];
    cdeg_q[0] <= fdeg; cdeg_q[1] <= cdeg_q[0];
  end

  // right axis
  logic rv;
  logic signed [WB-1:0] r0, r1, r2;
  logic rdeg;
  lavm_unit_vec #(.WORD_BITS(WB), .FRAC_BITS(FRAC_BITS)) u_r (
    .clk_i, .rst_ni, .valid_i(cv_q[1]), .v0_i(c1_q[0]), .v1_i(c1_q[1]), .v2_i(c1_q[2]),
    .valid_o(rv), .n0_o(r0), .n1_o(r1), .n2_o(r2), .deg_o(rdeg));

  logic signed [WB-1:0] fl_q [NL+1][3];
  logic dl_q [NL+1];
  always_comb begin
    fl_q[0] = fd_q[1]; dl_q[0] = cdeg_q[1];
  end
  for (genvar g = 0; g < NL; g++) begin : g_fline
    always_ff @(posedge clk_i) begin
      fl_q[g+1] <= fl_q[g]; dl_q[g+1] <= dl_q[g];
    end
  end

  // cross(f, r)
  logic signed [VB-1:0] p2_q [6];
  logic signed [VB-1:0] c2_q [3];
  logic signed [WB-1:0] fe_q [2][3];
  logic signed [WB-1:0] re_q [2][3];
  logic ev_q [2];
  logic edeg_q [2];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin ev_q[0] <= 1'b0; ev_q[1] <= 1'b0; end
    else begin ev_q[0] <= rv; ev_q[1] <= ev_q[0]; end
  end
  always_ff @(posedge clk_i) begin
    p2_q[0] <= VB'(fl_q[NL][1]) * VB'(r2);
    p2_q[1] <= VB'(fl_q[NL][2]) * VB'(r1);
    p2_q[2] <= VB'(fl_q[NL][2]) * VB'(r0);
    p2_q[3] <= VB'(fl_q[NL][0]) * VB'(r2);
    p2_q[4] <= VB'(fl_q[NL][0]) * VB'(r1);
    p2_q[5] <= VB'(fl_q[NL][1]) * VB'(r0);
    c2_q[0] <= p2_q[0] - p2_q[1];
    c2_q[1] <= p2_q[2] - p2_q[3];
    c2_q[2] <= p2_q[4] - p2_q[5];
    fe_q[0] <= fl_q[NL]; fe_q[1] <= fe_q[0];
    re_q[0] <= '{r0, r1, r2}; re_q[1] <= re_q[0];
    edeg_q[0] <= dl_q[NL] | rdeg; edeg_q[1] <= edeg_q[0];
  end

  // true up axis
  logic uv;
  logic signed [WB-1:0] w0, w1, w2;
  logic udeg;
  lavm_unit_vec #(.WORD_BITS(WB), .FRAC_BITS(FRAC_BITS)) u_u (
    .clk_i, .rst_ni, .valid_i(ev_q[1]), .v0_i(c2_q[0]), .v1_i(c2_q[1]), .v2_i(c2_q[2]),
    .valid_o(uv), .n0_o(w0), .n1_o(w1), .n2_o(w2), .deg_o(udeg));

  logic signed [WB-1:0] fm_q [NL+1][3];
  logic signed [WB-1:0] rm_q [NL+1][3];
  logic dm_q [NL+1];
  always_comb begin
    fm_q[0] = fe_q[1]; rm_q[0] = re_q[1]; dm_q[0] = edeg_q[1];
  end
  for (genvar g = 0; g < NL; g++) begin : g_mline
    always_ff @(posedge clk_i) begin
      fm_q[g+1] <= fm_q[g]; rm_q[g+1] <= rm_q[g]; dm_q[g+1] <= dm_q[g];
    end
  end

  // dot products: products, sums, rounding and saturation
  logic signed [VB-1:0] dp_q [3][3];
  logic signed [VB-1:0] ds_q [3];
  logic signed [WB-1:0] ax_q [2][3][3];
  logic xv_q [2];
  logic xd_q [2];
  logic signed [31:0] ee [3];
  assign ee = ed_q[PL];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin xv_q[0] <= 1'b0; xv_q[1] <= 1'b0; end
    else begin xv_q[0] <= uv; xv_q[1] <= xv_q[0]; end
  end
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      dp_q[0][k] <= VB'(rm_q[NL][k]) * VB'(ee[k]);
      dp_q[2][k] <= VB'(fm_q[NL][k]) * VB'(ee[k]);
    end
    dp_q[1][0] <= VB'(w0) * VB'(ee[0]);
    dp_q[1][1] <= VB'(w1) * VB'(ee[1]);
    dp_q[1][2] <= VB'(w2) * VB'(ee[2]);
    for (int a = 0; a < 3; a++) ds_q[a] <= dp_q[a][0] + dp_q[a][1] + dp_q[a][2];
    ax_q[0][0] <= rm_q[NL]; ax_q[0][1] <= '{w0, w1, w2}; ax_q[0][2] <= fm_q[NL];
    ax_q[1] <= ax_q[0];
    xd_q[0] <= dm_q[NL] | udeg; xd_q[1] <= xd_q[0];
  end

  logic signed [WB-1:0] nd_d [4];
  logic sat_d;
  always_comb begin
    logic signed [VB:0] hi;
    hi = $signed((VB+1)'({(WB-1){1'b1}}));
    sat_d = 1'b0;
    for (int a = 0; a < 3; a++) begin
      logic [VB-1:0] mag, q;
      logic signed [VB:0] r;
      mag = ds_q[a][VB-1] ? VB'(-ds_q[a]) : VB'(ds_q[a]);
      q = (mag + (VB'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      r = ds_q[a][VB-1] ? $signed((VB+1)'(q)) : -$signed((VB+1)'(q));
      if (r > hi) begin nd_d[a] = hi[WB-1:0]; sat_d = 1'b1; end
      else if (r < -hi - 1) begin nd_d[a] = WB'(-hi - 1); sat_d = 1'b1; end
      else nd_d[a] = r[WB-1:0];
    end
    if ((VB+1)'(1) << FRAC_BITS > hi) begin nd_d[3] = hi[WB-1:0]; sat_d = 1'b1; end
    else nd_d[3] = WB'(1) << FRAC_BITS;
  end

  // four-row output buffer
  logic signed [WB-1:0] m_q [4][4];
  logic mdeg_q;
  logic [2:0] cnt_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else if (xv_q[1]) cnt_q <= 3'd4;
    else if (cnt_q != 3'd0) cnt_q <= cnt_q - 3'd1;
  end
  always_ff @(posedge clk_i) begin
    if (xv_q[1]) begin
      for (int i = 0; i < 3; i++) begin
        m_q[i][0] <= ax_q[1][0][i];
        m_q[i][1] <= ax_q[1][1][i];
        m_q[i][2] <= ax_q[1][2][i];
        m_q[i][3] <= '0;
      end
      for (int j = 0; j < 4; j++) m_q[3][j] <= nd_d[j];
      mdeg_q <= xd_q[1] | sat_d;
    end
  end

  logic [1:0] row;
  assign row = 2'(3'd4 - cnt_q);
  assign valid_o = (cnt_q != 3'd0);
  assign row_index_o = row;
  assign elem0_o = 32'(m_q[row][0]);
  assign elem1_o = 32'(m_q[row][1]);
  assign elem2_o = 32'(m_q[row][2]);
  assign elem3_o = 32'(m_q[row][3]);
  assign last_row_o = (cnt_q == 3'd1);
  assign degenerate_o = mdeg_q;
endmodule

/* hdl/lavm_unit_vec.sv */
// pipelined vector normalizer: scale, sum of squares, root, three quotients
module lavm_unit_vec #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  logic signed [lavm_pkg::VEC_BITS-1:0] v0_i,
  input  logic signed [lavm_pkg::VEC_BITS-1:0] v1_i,
  input  logic signed [lavm_pkg::VEC_BITS-1:0] v2_i,
  output logic                                 valid_o,
  output logic signed [WORD_BITS-1:0]          n0_o,
  output logic signed [WORD_BITS-1:0]          n1_o,
  output logic signed [WORD_BITS-1:0]          n2_o,
  output logic                                 deg_o
);
  localparam int unsigned VB = lavm_pkg::VEC_BITS;
  localparam int unsigned NB = lavm_pkg::NRM_BITS;
  localparam int unsigned SB = lavm_pkg::SUM_BITS;
  localparam int unsigned RB = lavm_pkg::ROOT_BITS;
  localparam int unsigned SH = $clog2(VB + 1);
  localparam int unsigned DB = NB + FRAC_BITS + 1;
  localparam int unsigned QB = FRAC_BITS + 2;

  // stage a: magnitudes and leading-one position
  logic [VB-1:0] a0_d, a1_d, a2_d, mx;
  logic [2:0]    neg_d;
  logic [VB-1:0] a0_q, a1_q, a2_q;
  logic [2:0]    neg_a_q;
  logic [SH-1:0] lz_d, lz_q;
  logic          zero_d, va_q;

  always_comb begin
    neg_d = {v2_i[VB-1], v1_i[VB-1], v0_i[VB-1]};
    a0_d = v0_i[VB-1] ? VB'(-v0_i) : VB'(v0_i);
    a1_d = v1_i[VB-1] ? VB'(-v1_i) : VB'(v1_i);
    a2_d = v2_i[VB-1] ? VB'(-v2_i) : VB'(v2_i);
    mx = a0_d | a1_d | a2_d;
    zero_d = (mx == '0);
    lz_d = '0;
    for (int i = 0; i < VB; i++) begin
      if (mx[i]) lz_d = SH'(i);
    end
  end

  logic zero_a_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) va_q <= 1'b0;
    else va_q <= valid_i;
  end
  always_ff @(posedge clk_i) begin
    a0_q <= a0_d; a1_q <= a1_d; a2_q <= a2_d;
    neg_a_q <= neg_d; lz_q <= lz_d; zero_a_q <= zero_d;
  end

  // stage b: shift so the largest lies in [2^29, 2^30)
  lavm_pkg::nrm_t nb_d, nb_q;
  logic vb_q;
  always_comb begin
    logic [VB-1:0] s0, s1, s2;
    if (lz_q >= SH'(NB - 1)) begin
      s0 = a0_q >> (lz_q - SH'(NB - 1));
      s1 = a1_q >> (lz_q - SH'(NB - 1));
      s2 = a2_q >> (lz_q - SH'(NB - 1));
    end else begin
      s0 = a0_q << (SH'(NB - 1) - lz_q);
      s1 = a1_q << (SH'(NB - 1) - lz_q);
      s2 = a2_q << (SH'(NB - 1) - lz_q);
    end
    nb_d.a0 = s0[NB-1:0];
    nb_d.a1 = s1[NB-1:0];
    nb_d.a2 = s2[NB-1:0];
    nb_d.neg = neg_a_q;
    nb_d.zero = zero_a_q;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vb_q <= 1'b0;
    else vb_q <= va_q;
  end
  always_ff @(posedge clk_i) nb_q <= nb_d;

  // stage c: squares
  logic [SB-1:0] sq0_q, sq1_q, sq2_q;
  lavm_pkg::nrm_t nc_q;
  logic vc_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vc_q <= 1'b0;
    else vc_q <= vb_q;
  end
  always_ff @(posedge clk_i) begin
    sq0_q <= SB'(nb_q.a0) * SB'(nb_q.a0);
    sq1_q <= SB'(nb_q.a1) * SB'(nb_q.a1);
    sq2_q <= SB'(nb_q.a2) * SB'(nb_q.a2);
    nc_q <= nb_q;
  end

  // stage d: sum
  logic [SB+1:0] sum_q;
  lavm_pkg::nrm_t nd_q;
  logic vd_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vd_q <= 1'b0;
    else vd_q <= vc_q;
  end
  always_ff @(posedge clk_i) begin
    sum_q <= (SB+2)'(sq0_q) + (SB+2)'(sq1_q) + (SB+2)'(sq2_q);
    nd_q <= nc_q;
  end

  // square root, one result bit per stage
  localparam int unsigned RS = RB;
  logic [SB+1:0]  rx_q [RS+1];
  logic [RB-1:0]  rr_q [RS+1];
  lavm_pkg::nrm_t rn_q [RS+1];
  logic           rv_q [RS+1];
  always_comb begin
    rx_q[0] = sum_q; rr_q[0] = '0; rn_q[0] = nd_q; rv_q[0] = vd_q;
  end
  for (genvar g = 0; g < RS; g++) begin : g_sqrt
    logic [SB+1:0] rem_d;
    logic [RB-1:0] root_d;
    logic [SB+1:0] trial;
    always_comb begin
      logic [SB+1:0] cur;
      cur = rx_q[g] >> (2 * (RS - 1 - g));
      trial = (SB+2)'({rr_q[g], 2'b01});
      if (cur[RB+1:0] >= trial[RB+1:0] && (cur >> (RB + 2)) == '0
          || (cur >> (RB + 2)) != '0) begin
        rem_d = rx_q[g] - (trial << (2 * (RS - 1 - g)));
        root_d = {rr_q[g][RB-2:0], 1'b1};
      end else begin
        rem_d = rx_q[g];
        root_d = {rr_q[g][RB-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) rv_q[g+1] <= 1'b0;
      else rv_q[g+1] <= rv_q[g];
    end
    always_ff @(posedge clk_i) begin
      rx_q[g+1] <= rem_d; rr_q[g+1] <= root_d; rn_q[g+1] <= rn_q[g];
    end
  end

  // restoring divides, one quotient bit per stage for all three lanes
  logic [DB-1:0]  dr_q [3][QB+1];
  logic [QB-1:0]  dq_q [3][QB+1];
  logic [RB-1:0]  dm_q [QB+1];
  logic [2:0]     dn_q [QB+1];
  logic           dz_q [QB+1];
  logic           dv_q [QB+1];
  always_comb begin
    dr_q[0][0] = (DB'(rn_q[RS].a0) << FRAC_BITS) + DB'(rr_q[RS] >> 1);
    dr_q[1][0] = (DB'(rn_q[RS].a1) << FRAC_BITS) + DB'(rr_q[RS] >> 1);
    dr_q[2][0] = (DB'(rn_q[RS].a2) << FRAC_BITS) + DB'(rr_q[RS] >> 1);
    dq_q[0][0] = '0; dq_q[1][0] = '0; dq_q[2][0] = '0;
    dm_q[0] = rr_q[RS]; dn_q[0] = rn_q[RS].neg;
    dz_q[0] = rn_q[RS].zero; dv_q[0] = rv_q[RS];
  end
  for (genvar g = 0; g < QB; g++) begin : g_div
    logic [DB-1:0] r_d [3];
    logic [QB-1:0] q_d [3];
    always_comb begin
      for (int l = 0; l < 3; l++) begin
        logic [DB+QB-1:0] dv;
        dv = (DB+QB)'(dm_q[g]) << (QB - 1 - g);
        if ((DB+QB)'(dr_q[l][g]) >= dv) begin
          r_d[l] = dr_q[l][g] - DB'(dv);
          q_d[l] = {dq_q[l][g][QB-2:0], 1'b1};
        end else begin
          r_d[l] = dr_q[l][g];
          q_d[l] = {dq_q[l][g][QB-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_q[g+1] <= 1'b0;
      else dv_q[g+1] <= dv_q[g];
    end
    always_ff @(posedge clk_i) begin
      dr_q[0][g+1] <= r_d[0]; dr_q[1][g+1] <= r_d[1]; dr_q[2][g+1] <= r_d[2];
      dq_q[0][g+1] <= q_d[0]; dq_q[1][g+1] <= q_d[1]; dq_q[2][g+1] <= q_d[2];
      dm_q[g+1] <= dm_q[g]; dn_q[g+1] <= dn_q[g]; dz_q[g+1] <= dz_q[g];
    end
  end

  // sign, saturation, zero vector
  localparam int unsigned OB = (WORD_BITS > QB) ? WORD_BITS : QB + 1;
  logic signed [WORD_BITS-1:0] o_d [3];
  logic sat_d;
  always_comb begin
    sat_d = 1'b0;
    for (int l = 0; l < 3; l++) begin
      logic signed [OB:0] s;
      logic signed [OB:0] hi;
      s = dn_q[QB][l] ? -$signed((OB+1)'(dq_q[l][QB])) : $signed((OB+1)'(dq_q[l][QB]));
      hi = $signed((OB+1)'({(WORD_BITS-1){1'b1}}));
      if (dz_q[QB]) o_d[l] = '0;
      else if (s > hi) begin o_d[l] = hi[WORD_BITS-1:0]; sat_d = 1'b1; end
      else if (s < -hi - 1) begin o_d[l] = WORD_BITS'(-hi - 1); sat_d = 1'b1; end
      else o_d[l] = s[WORD_BITS-1:0];
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else valid_o <= dv_q[QB];
  end
  always_ff @(posedge clk_i) begin
    n0_o <= o_d[0]; n1_o <= o_d[1]; n2_o <= o_d[2];
    deg_o <= dz_q[QB] | sat_d;
  end
endmodule

/* verif/look_at_view_matrix_unit_tb.sv */
// self-checking testbench for the look-at view matrix unit
`timescale 1ns / 100ps

module look_at_view_matrix_unit_tb;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 600;
  localparam int NUM_RANDOM = 430;

  typedef longint vec3_t [3];

  typedef struct {
    logic signed [31:0] eye [3];
    logic signed [31:0] tgt [3];
    logic signed [31:0] up [3];
  } view_word_t;

  typedef struct {
    logic [1:0]         row;
    logic signed [31:0] e [4];
    logic               last;
    logic               deg;
  } matrix_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] eye_x_i = '0, eye_y_i = '0, eye_z_i = '0;
  logic signed [31:0] target_x_i = '0, target_y_i = '0, target_z_i = '0;
  logic signed [31:0] upvec_x_i = '0, upvec_y_i = '0, upvec_z_i = '0;
  logic valid_o;
  logic [1:0] row_index_o;
  logic signed [31:0] elem0_o, elem1_o, elem2_o, elem3_o;
  logic last_row_o, degenerate_o;

  view_word_t pending_words [$];
  matrix_row_t expected_rows [$];
  int errors = 0;
  int words_taken = 0;
  int cycles = 0;

  look_at_view_matrix_unit #(
    .WORD_BITS(WORD_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .eye_x_i(eye_x_i), .eye_y_i(eye_y_i), .eye_z_i(eye_z_i),
    .target_x_i(target_x_i), .target_y_i(target_y_i), .target_z_i(target_z_i),
    .upvec_x_i(upvec_x_i), .upvec_y_i(upvec_y_i), .upvec_z_i(upvec_z_i),
    .valid_o(valid_o), .row_index_o(row_index_o),
    .elem0_o(elem0_o), .elem1_o(elem1_o), .elem2_o(elem2_o), .elem3_o(elem3_o),
    .last_row_o(last_row_o), .degenerate_o(degenerate_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic longint clamp_word(input longint v, inout bit deg);
    longint hi, lo;
    hi = (longint'(1) <<< (WORD_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      deg = 1'b1;
      return hi;
    end
    if (v < lo) begin
      deg = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic void normalize(input vec3_t v, output vec3_t n, inout bit deg);
    longint unsigned a [3];
    longint unsigned mx, sum, m, q;
    bit neg [3];
    mx = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      a[i] = neg[i] ? longint'(-v[i]) : longint'(v[i]);
      if (a[i] > mx) mx = a[i];
    end
    if (mx == 0) begin
      n = '{0, 0, 0};
      deg = 1'b1;
      return;
    end
    while (mx >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) a[i] >>= 1;
      mx >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) a[i] <<= 1;
      mx <<= 1;
    end
    for (int i = 0; i < 3; i++) sum += a[i] * a[i];
    m = floor_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((a[i] << FRAC_BITS) + (m >> 1)) / m;
      n[i] = clamp_word(neg[i] ? -longint'(q) : longint'(q), deg);
    end
  endfunction

  function automatic void cross_vec(input vec3_t a, input vec3_t b, output vec3_t d);
    d[0] = a[1] * b[2] - a[2] * b[1];
    d[1] = a[2] * b[0] - a[0] * b[2];
    d[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic longint neg_dot_eye(input vec3_t u, input vec3_t p, inout bit deg);
    longint s;
    longint unsigned a, q;
    s = u[0] * p[0] + u[1] * p[1] + u[2] * p[2];
    a = (s < 0) ? longint'(-s) : longint'(s);
    q = (a + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return clamp_word((s < 0) ? longint'(q) : -longint'(q), deg);
  endfunction

  task automatic predict_view_rows(input view_word_t w);
    vec3_t eye, up, d, f, c, r, u;
    longint mat [4][4];
    bit deg;
    matrix_row_t row;
    deg = 1'b0;
    for (int i = 0; i < 3; i++) begin
      eye[i] = w.eye[i];
      up[i] = w.up[i];
      d[i] = longint'(w.eye[i]) - longint'(w.tgt[i]);
    end
    normalize(d, f, deg);
    cross_vec(up, f, c);
    normalize(c, r, deg);
    cross_vec(f, r, c);
    normalize(c, u, deg);
    for (int i = 0; i < 3; i++) begin
      mat[i][0] = r[i];
      mat[i][1] = u[i];
      mat[i][2] = f[i];
      mat[i][3] = 0;
    end
    mat[3][0] = neg_dot_eye(r, eye, deg);
    mat[3][1] = neg_dot_eye(u, eye, deg);
    mat[3][2] = neg_dot_eye(f, eye, deg);
    mat[3][3] = clamp_word(longint'(1) <<< FRAC_BITS, deg);
    for (int i = 0; i < 4; i++) begin
      row.row = 2'(i);
      for (int j = 0; j < 4; j++) row.e[j] = mat[i][j][31:0];
      row.last = (i == 3);
      row.deg = deg;
      expected_rows.push_back(row);
    end
  endtask

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("t=%0t %s: got %0h expected %0h", $realtime, what, got, want);
  endtask

  function automatic int sender_idle_pct();
    if (words_taken < 150) return 35;
    if (words_taken < 300) return 69;
    return 0;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    view_word_t w;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        w.eye = '{eye_x_i, eye_y_i, eye_z_i};
        w.tgt = '{target_x_i, target_y_i, target_z_i};
        w.up = '{upvec_x_i, upvec_y_i, upvec_z_i};
        predict_view_rows(w);
        words_taken++;
      end
      if (!start || !busy) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
          w = pending_words.pop_front();
          start <= 1'b1;
          {eye_x_i, eye_y_i, eye_z_i} <= {w.eye[0], w.eye[1], w.eye[2]};
          {target_x_i, target_y_i, target_z_i} <= {w.tgt[0], w.tgt[1], w.tgt[2]};
          {upvec_x_i, upvec_y_i, upvec_z_i} <= {w.up[0], w.up[1], w.up[2]};
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    matrix_row_t want;
    if (rst_ni && valid_o) begin
      if (expected_rows.size() == 0) begin
        report("unexpected row", row_index_o, 0);
      end else begin
        want = expected_rows.pop_front();
        if (row_index_o !== want.row) report("row_index", row_index_o, want.row);
        if (elem0_o !== want.e[0]) report("elem0", elem0_o, want.e[0]);
        if (elem1_o !== want.e[1]) report("elem1", elem1_o, want.e[1]);
        if (elem2_o !== want.e[2]) report("elem2", elem2_o, want.e[2]);
        if (elem3_o !== want.e[3]) report("elem3", elem3_o, want.e[3]);
        if (last_row_o !== want.last) report("last_row", last_row_o, want.last);
        if (degenerate_o !== want.deg) report("degenerate", degenerate_o, want.deg);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("look_at_view_matrix_unit: mismatch");
      $finish;
    end
  end

  task automatic add_word(input int ex, ey, ez, tx, ty, tz, ux, uy, uz);
    view_word_t w;
    w.eye = '{ex, ey, ez};
    w.tgt = '{tx, ty, tz};
    w.up = '{ux, uy, uz};
    pending_words.push_back(w);
  endtask

  function automatic int rand_coord(input int kind);
    case (kind)
      0: return $urandom;
      1: return int'($urandom_range(2 * 1048576)) - 1048576;
      default: return int'($urandom_range(2 * 65536)) - 65536;
    endcase
  endfunction

  initial begin
    int ONE, MAXV, MINV;
    int kind, ex, ey, ez, tx, ty, tz, k;
    ONE = 1 << FRAC_BITS;
    MAXV = 32'h7fffffff;
    MINV = 32'h80000000;
    // directed words
    add_word(0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_word(0, 0, 5 * ONE, 0, 0, 0, 0, ONE, 0);
    add_word(ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE, 0, ONE, 0);
    add_word(0, 0, ONE, 0, 0, 0, 0, 0, 0);
    add_word(0, 0, ONE, 0, 0, 0, 0, 0, 3 * ONE);
    add_word(0, 0, ONE, 0, 0, 0, 0, 0, -ONE);
    add_word(MAXV, MAXV, MAXV, MINV, MINV, MINV, 0, ONE, 0);
    add_word(MINV, MINV, MINV, MAXV, MAXV, MAXV, MINV, MAXV, MINV);
    add_word(MAXV, MINV, MAXV, 0, 0, 0, MAXV, MAXV, MAXV);
    add_word(MAXV, MAXV, MAXV, 0, 0, 0, ONE, 0, 0);
    add_word(MINV, MINV, MINV, MAXV, 0, MINV, 1, -1, 1);
    add_word(1, 0, 0, 0, 0, 0, 0, 1, 0);
    add_word(-1, -1, -1, 0, 0, 0, -1, 1, 0);
    add_word(3 * ONE, 4 * ONE, -2 * ONE, ONE, 0, ONE, 0, ONE, 0);
    add_word(-7 * ONE, ONE / 2, 9 * ONE, 2 * ONE, -ONE, 0, ONE, ONE, 0);
    add_word(MAXV, 0, 0, MAXV - 1, 0, 0, 0, 0, MAXV);
    add_word(-1, -1, -1, -1, -1, -1, -1, -1, -1);
    // random words
    for (int n = 0; n < NUM_RANDOM; n++) begin
      kind = $urandom_range(2);
      ex = rand_coord(kind); ey = rand_coord(kind); ez = rand_coord(kind);
      tx = rand_coord(kind); ty = rand_coord(kind); tz = rand_coord(kind);
      case ($urandom_range(19))
        0: add_word(ex, ey, ez, ex, ey, ez, rand_coord(kind), rand_coord(kind),
                    rand_coord(kind));
        1: add_word(ex, ey, ez, tx, ty, tz, 0, 0, 0);
        2: begin
          k = $urandom_range(1, 3);
          add_word(ex, ey, ez, ex - k, ey - 2 * k, ez - 3 * k, 1, 2, 3);
        end
        default: add_word(ex, ey, ez, tx, ty, tz, rand_coord(kind),
                          rand_coord(kind), rand_coord(kind));
      endcase
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_words.size() > 0 || start) @(posedge clk_i);
    while (expected_rows.size() > 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("look_at_view_matrix_unit: match");
    end else begin
      $display("look_at_view_matrix_unit: mismatch");
    end
    $finish;
  end

endmodule
